### rtl/core/mmio_range_decoder_core_macros.svh
// Assertion helpers for the checker file of the range decoder.
`ifndef MMIO_RANGE_DECODER_CORE_MACROS_SVH
`define MMIO_RANGE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk and idle during reset.
`define MMIODEC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and idle during reset.
`define MMIODEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mmiodec_pkg.sv
package mmiodec_pkg;

    // Default table depth.
    localparam int MAX_DEVICES_DEF = 16;

    // Accesses are relative to this window base.
    localparam logic [31:0] WINDOW_BASE = 32'h0100_0000;

    // Action codes of an input word.
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // Status codes of a result word.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_UNASSIGNED = 3'd1;
    localparam logic [2:0] ST_OVERLAP    = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_INVALID    = 3'd4;

    // Lookup token that travels down the row of table cells.
    typedef struct packed {
        logic        valid;
        logic [1:0]  action;
        logic [31:0] addr;       // range start for an add, absolute address for an access
        logic [32:0] end_addr;   // exclusive end of a range being added
        logic        bad_range;
        logic [3:0]  width;
        logic        found;
        logic [3:0]  hit_id;
        logic [31:0] hit_offset;
        logic        overlap;
    } dec_token_t;

    // Table write broadcast to all cells.
    typedef struct packed {
        logic        en;
        logic [31:0] start;
        logic [32:0] end_addr;
    } entry_wr_t;

    // One result word.
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  device_index;
        logic [31:0] offset;
        logic        is_write;
        logic [3:0]  width_bytes;
        logic        zero_fill;
    } dec_result_t;

endpackage

### rtl/core/mmiodec_cell.sv
module mmiodec_cell
    import mmiodec_pkg::*;
#(
    parameter int CELL_ID = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  dec_token_t tok_in,
    input  entry_wr_t  wr,
    input  logic       wr_sel,
    output dec_token_t tok_out
);

    logic        entry_valid_reg;
    logic [31:0] start_reg;
    logic [32:0] end_reg;
    dec_token_t  tok_reg;
    dec_token_t  tok_next;
    logic        is_access;
    logic        hit;
    logic        overlap_here;

    // Compare the passing token against the range this cell holds.
    always_comb begin
        is_access    = (tok_in.action == ACT_READ) || (tok_in.action == ACT_WRITE);
        hit          = entry_valid_reg && tok_in.valid && is_access && !tok_in.found &&
                       (tok_in.addr >= start_reg) && ({1'b0, tok_in.addr} < end_reg);
        overlap_here = entry_valid_reg && tok_in.valid && (tok_in.action == ACT_ADD) &&
                       ({1'b0, tok_in.addr} < end_reg) &&
                       ({1'b0, start_reg} < tok_in.end_addr);
        tok_next = tok_in;
        if (hit) begin
            tok_next.found      = 1'b1;
            tok_next.hit_id     = 4'(CELL_ID);
            tok_next.hit_offset = tok_in.addr - start_reg;
        end
        if (overlap_here) begin
            tok_next.overlap = 1'b1;
        end
    end

    // Hand the token to the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    // Entry valid flag, cleared at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
        end else if (wr.en && wr_sel) begin
            entry_valid_reg <= 1'b1;
        end
    end

    // Range bounds, written once when the entry is added.
    always_ff @(posedge aclk) begin
        if (wr.en && wr_sel) begin
            start_reg <= wr.start;
            end_reg   <= wr.end_addr;
        end
    end

    assign tok_out = tok_reg;

endmodule

### rtl/core/mmio_range_decoder_core.sv
// Programmable address range decoder. Holds up to MAX_DEVICES non-overlapping
// ranges, one per cell of a chain; the table is empty after reset. An add word
// stores [addr, addr + range_size) under the next free id, or is refused for a
// zero or wrapping size, a full table, or an overlap. A read or write word is
// offset by the window base 0x01000000 and looked up, returning the id and the
// offset inside the matching range, or unassigned status (zero-filled for a
// read). One word is processed at a time: it walks the chain one cell per
// cycle, its result is held in a pending register, and the next word is
// accepted once that result has moved into the output register, which may
// still be waiting to be taken.
module mmio_range_decoder_core
    import mmiodec_pkg::*;
#(
    parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_addr,
    input  logic [31:0] s_range_size,
    input  logic [3:0]  s_access_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_device_index,
    output logic [31:0] m_offset,
    output logic        m_is_write,
    output logic [3:0]  m_width_bytes,
    output logic        m_zero_fill
);

    localparam int CNT_W = $clog2(MAX_DEVICES + 1);

    logic                   busy_reg;
    logic                   busy_next;
    logic [CNT_W-1:0]       count_reg;
    logic                   pend_valid_reg;
    dec_result_t            pend_reg;
    logic                   out_valid_reg;
    dec_result_t            out_reg;
    dec_token_t             chain [0:MAX_DEVICES];
    dec_token_t             tail;
    entry_wr_t              wr;
    logic [MAX_DEVICES-1:0] wr_sel;
    logic                   accept;
    logic [32:0]            head_end;
    logic                   full;
    logic                   add_ok;
    logic                   pend_move;
    dec_result_t            res;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !busy_reg;
    assign pend_move = pend_valid_reg && (!out_valid_reg || m_ready);

    // Build the token that enters the first cell.
    always_comb begin
        head_end            = {1'b0, s_addr} + {1'b0, s_range_size};
        chain[0]            = '0;
        chain[0].valid      = accept;
        chain[0].action     = s_action;
        chain[0].addr       = (s_action == ACT_ADD) ? s_addr : s_addr + WINDOW_BASE;
        chain[0].end_addr   = head_end;
        chain[0].bad_range  = (s_range_size == 32'd0) ||
                              (head_end[32] && (head_end[31:0] != 32'd0));
        chain[0].width      = s_access_bytes;
    end

    // Row of table cells.
    for (genvar i = 0; i < MAX_DEVICES; i++) begin : g_cell
        assign wr_sel[i] = (count_reg == CNT_W'(i));
        mmiodec_cell #(
            .CELL_ID (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (chain[i]),
            .wr      (wr),
            .wr_sel  (wr_sel[i]),
            .tok_out (chain[i+1])
        );
    end

    assign tail = chain[MAX_DEVICES];

    // Decide the outcome once the token leaves the last cell.
    always_comb begin
        full   = (count_reg == CNT_W'(MAX_DEVICES));
        add_ok = tail.valid && (tail.action == ACT_ADD) && !tail.bad_range &&
                 !full && !tail.overlap;
        wr.en       = add_ok;
        wr.start    = tail.addr;
        wr.end_addr = tail.end_addr;
        res = '0;
        unique case (tail.action)
            ACT_ADD: begin
                if (tail.bad_range) begin
                    res.status = ST_INVALID;
                end else if (full) begin
                    res.status = ST_FULL;
                end else if (tail.overlap) begin
                    res.status = ST_OVERLAP;
                end else begin
                    res.status       = ST_OK;
                    res.device_index = 4'(count_reg);
                end
            end
            ACT_READ, ACT_WRITE: begin
                res.is_write    = (tail.action == ACT_WRITE);
                res.width_bytes = tail.width;
                if (tail.found) begin
                    res.status       = ST_OK;
                    res.device_index = tail.hit_id;
                    res.offset       = tail.hit_offset;
                end else begin
                    res.status    = ST_UNASSIGNED;
                    res.zero_fill = (tail.action == ACT_READ);
                end
            end
            default: begin
                res.status = ST_INVALID;
            end
        endcase
    end

    // Entry count and busy flag.
    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (pend_move) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            if (add_ok) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // Pending result and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (tail.valid) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_move) begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tail.valid) begin
            pend_reg <= res;
        end
        if (pend_move) begin
            out_reg <= pend_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_reg.status;
    assign m_device_index = out_reg.device_index;
    assign m_offset       = out_reg.offset;
    assign m_is_write     = out_reg.is_write;
    assign m_width_bytes  = out_reg.width_bytes;
    assign m_zero_fill    = out_reg.zero_fill;

endmodule

### rtl/core/mmiodec_checker.sv
`include "mmio_range_decoder_core_macros.svh"

module mmiodec_checker
    import mmiodec_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [3:0]  m_device_index,
    input logic [31:0] m_offset,
    input logic        m_is_write,
    input logic [3:0]  m_width_bytes,
    input logic        m_zero_fill
);

    // Only one word is in flight: after an accept the input side closes.
    `MMIODEC_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready,
        "second word accepted while busy")

    // Zero fill is only ever asked for by an unassigned read.
    `MMIODEC_ASSERT_NOW(a_zero_fill_miss, m_valid && m_zero_fill,
        (m_status == ST_UNASSIGNED) && !m_is_write,
        "zero fill on a word that is not an unassigned read")

    // An unassigned access reports neither an id nor an offset.
    `MMIODEC_ASSERT_NOW(a_miss_fields, m_valid && (m_status == ST_UNASSIGNED),
        (m_device_index == 4'd0) && (m_offset == 32'd0),
        "unassigned access carries id or offset")

    // A stalled result holds its payload.
    `MMIODEC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_offset) && $stable(m_device_index) &&
        $stable(m_is_write) && $stable(m_width_bytes) && $stable(m_zero_fill),
        "stalled result changed")

endmodule

bind mmio_range_decoder_core mmiodec_checker u_mmiodec_checker (.*);

### tb/sv/mmio_range_decoder_core_tb.sv
module mmio_range_decoder_core_tb;
    import mmiodec_pkg::*;

    localparam int TABLE_DEPTH = MAX_DEVICES_DEF;
    // The action code that the block does not define.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 1250;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_AT = 800;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;

    // One directed word, with its result typed in when it is obvious.
    typedef struct {
        logic [1:0]  action;
        logic [31:0] addr;
        logic [31:0] size;
        logic [3:0]  bytes;
        bit          typed;
        dec_result_t want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [31:0] s_addr;
    logic [31:0] s_range_size;
    logic [3:0]  s_access_bytes;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [3:0]  m_device_index;
    logic [31:0] m_offset;
    logic        m_is_write;
    logic [3:0]  m_width_bytes;
    logic        m_zero_fill;

    // Shadow copy of the range table.
    logic [31:0] map_lo [TABLE_DEPTH];
    logic [32:0] map_hi [TABLE_DEPTH];
    bit          map_used [TABLE_DEPTH];
    int          map_count = 0;

    dec_result_t pending_decodes [$];
    stim_row_t   directed_rows [$];
    int          mismatches = 0;
    int          results_seen = 0;
    bit          hold_req = 1'b0;

    mmio_range_decoder_core #(
        .MAX_DEVICES(TABLE_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_addr(s_addr),
        .s_range_size(s_range_size),
        .s_access_bytes(s_access_bytes),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_device_index(m_device_index),
        .m_offset(m_offset),
        .m_is_write(m_is_write),
        .m_width_bytes(m_width_bytes),
        .m_zero_fill(m_zero_fill)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Computes the result of one word and updates the shadow table.
    function automatic dec_result_t decode_predict(logic [1:0] act, logic [31:0] addr,
                                                   logic [31:0] size, logic [3:0] bytes);
        dec_result_t r;
        logic [32:0] stop;
        logic [31:0] abs_addr;
        bit          clash;
        r = '0;
        case (act)
            ACT_ADD: begin
                stop = {1'b0, addr} + {1'b0, size};
                clash = 1'b0;
                if (size == 32'd0 || stop > 33'h1_0000_0000) begin
                    r.status = ST_INVALID;
                end else if (map_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (map_used[i] && {1'b0, addr} < map_hi[i] && {1'b0, map_lo[i]} < stop)
                            clash = 1'b1;
                    end
                    if (clash) begin
                        r.status = ST_OVERLAP;
                    end else begin
                        map_lo[map_count] = addr;
                        map_hi[map_count] = stop;
                        map_used[map_count] = 1'b1;
                        r.status = ST_OK;
                        r.device_index = 4'(map_count);
                        map_count++;
                    end
                end
            end
            ACT_READ, ACT_WRITE: begin
                abs_addr = addr + WINDOW_BASE;
                r.status = ST_UNASSIGNED;
                r.is_write = (act == ACT_WRITE);
                r.width_bytes = bytes;
                r.zero_fill = (act == ACT_READ);
                // Walk downward so that the lowest matching id wins.
                for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
                    if (map_used[i] && abs_addr >= map_lo[i] && {1'b0, abs_addr} < map_hi[i]) begin
                        r.status = ST_OK;
                        r.device_index = 4'(i);
                        r.offset = abs_addr - map_lo[i];
                        r.zero_fill = 1'b0;
                    end
                end
            end
            default: begin
                r.status = ST_INVALID;
            end
        endcase
        return r;
    endfunction

    function automatic stim_row_t mk_row(logic [1:0] act, logic [31:0] addr, logic [31:0] size,
                                         logic [3:0] bytes, bit typed, logic [2:0] st,
                                         logic [3:0] idx, logic [31:0] off, logic wr,
                                         logic [3:0] wb, logic zf);
        stim_row_t row;
        row.action = act;
        row.addr = addr;
        row.size = size;
        row.bytes = bytes;
        row.typed = typed;
        row.want.status = st;
        row.want.device_index = idx;
        row.want.offset = off;
        row.want.is_write = wr;
        row.want.width_bytes = wb;
        row.want.zero_fill = zf;
        return row;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_mismatch(string what);
        mismatches++;
        $display("MISMATCH: %s", what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("word %0d %s got %h want %h", results_seen, name, got, want));
    endtask

    // Offers one word after an optional idle stretch and waits until it is taken.
    task automatic offer_word(logic [1:0] act, logic [31:0] addr, logic [31:0] size,
                              logic [3:0] bytes, int idle);
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_addr <= addr;
        s_range_size <= size;
        s_access_bytes <= bytes;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Result side: random stalls, long ready stretches, and one long hold-off on request.
    initial begin
        int run;
        int idle;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                run = ($urandom_range(0, 99) < 10) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 8);
                m_ready <= 1'b1;
                repeat (run) @(posedge aclk);
                idle = pick_idle();
                if (idle > 0) begin
                    m_ready <= 1'b0;
                    repeat (idle) @(posedge aclk);
                end
            end
        end
    end

    // Compare each result word against the oldest expectation.
    always @(posedge aclk) begin
        dec_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_decodes.size() == 0) begin
                note_mismatch($sformatf("word %0d arrived with nothing pending", results_seen));
            end else begin
                want = pending_decodes.pop_front();
                check_field("status", 32'(m_status), 32'(want.status));
                check_field("device_index", 32'(m_device_index), 32'(want.device_index));
                check_field("offset", m_offset, want.offset);
                check_field("is_write", 32'(m_is_write), 32'(want.is_write));
                check_field("width_bytes", 32'(m_width_bytes), 32'(want.width_bytes));
                check_field("zero_fill", 32'(m_zero_fill), 32'(want.zero_fill));
            end
            results_seen++;
        end
    end

    // Stimulus: directed rows, then random words.
    initial begin
        stim_row_t   row;
        dec_result_t want;
        logic [1:0]  act;
        logic [31:0] addr;
        logic [31:0] size;
        logic [3:0]  bytes;
        logic [31:0] point;
        longint unsigned span;
        int          k;
        int          idle;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = ACT_ADD;
        s_addr = '0;
        s_range_size = '0;
        s_access_bytes = '0;

        // Empty table, refused adds, ranges at both ends of the address space.
        directed_rows.push_back(mk_row(ACT_READ, 32'h0, 32'h0, 4'd1, 1,
                                       ST_UNASSIGNED, 4'd0, 32'h0, 1'b0, 4'd1, 1'b1));
        directed_rows.push_back(mk_row(ACT_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd8, 1,
                                       ST_UNASSIGNED, 4'd0, 32'h0, 1'b1, 4'd8, 1'b0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h0100_0000, 32'h0, 4'd0, 1,
                                       ST_INVALID, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'hFFFF_FFFF, 32'h2, 4'd0, 1,
                                       ST_INVALID, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'hFFFF_FFF0, 32'h10, 4'd0, 1,
                                       ST_OK, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h0100_0000, 32'h100, 4'd0, 1,
                                       ST_OK, 4'd1, 32'h0, 1'b0, 4'd0, 1'b0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h0100_00FF, 32'h1, 4'd0, 1,
                                       ST_OVERLAP, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h0100_0100, 32'h100, 4'd0, 1,
                                       ST_OK, 4'd2, 32'h0, 1'b0, 4'd0, 1'b0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h0, 32'hFFFF_FFFF, 4'd15, 1,
                                       ST_OVERLAP, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'hFFFF_FFFF, 32'h1, 4'd0, 1,
                                       ST_OVERLAP, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0));
        // Accesses at and just past range edges, at the top of the space, and across the address wrap, plus more adds.
        directed_rows.push_back(mk_row(ACT_READ, 32'h0, 32'h0, 4'd4, 0, '0, '0, '0, '0, '0, '0));
        directed_rows.push_back(mk_row(ACT_READ, 32'hFF, 32'h0, 4'd8, 0, '0, '0, '0, '0, '0, '0));
        directed_rows.push_back(mk_row(ACT_WRITE, 32'h100, 32'h0, 4'd2, 0, '0, '0, '0, '0, '0, '0));
        directed_rows.push_back(mk_row(ACT_READ, 32'hFEFF_FFFF, 32'h0, 4'd1, 0,
                                       '0, '0, '0, '0, '0, '0));
        directed_rows.push_back(mk_row(ACT_WRITE, 32'hFEFF_FFF0, 32'h0, 4'd0, 0,
                                       '0, '0, '0, '0, '0, '0));
        directed_rows.push_back(mk_row(ACT_READ, 32'h200, 32'h0, 4'd15, 0, '0, '0, '0, '0, '0, '0));
        directed_rows.push_back(mk_row(ACT_READ, 32'hFF00_0000, 32'h0, 4'd2, 0,
                                       '0, '0, '0, '0, '0, '0));
        directed_rows.push_back(mk_row(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1,
                                       ST_INVALID, 4'd0, 32'h0, 1'b0, 4'd0, 1'b0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h0, 32'h0100_0000, 4'd0, 0,
                                       '0, '0, '0, '0, '0, '0));
        directed_rows.push_back(mk_row(ACT_READ, 32'hFFFF_FFFF, 32'h0, 4'd1, 0,
                                       '0, '0, '0, '0, '0, '0));
        directed_rows.push_back(mk_row(ACT_ADD, 32'h8000_0000, 32'h8000_0000, 4'd0, 0,
                                       '0, '0, '0, '0, '0, '0));
        directed_rows.push_back(mk_row(ACT_WRITE, 32'h7F00_0000, 32'h0, 4'd9, 0,
                                       '0, '0, '0, '0, '0, '0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            offer_word(row.action, row.addr, row.size, row.bytes, pick_idle());
            want = decode_predict(row.action, row.addr, row.size, row.bytes);
            pending_decodes.push_back(row.typed ? row.want : want);
        end

        // Let the directed words drain before the random part starts.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_decodes.size() != 0) @(posedge aclk);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            k = $urandom_range(0, 99);
            act = (k < 15) ? ACT_ADD : (k < 17) ? ACT_UNUSED :
                  (k < 59) ? ACT_READ : ACT_WRITE;
            bytes = ($urandom_range(0, 99) < 60) ? 4'(1 << $urandom_range(0, 3))
                                                 : 4'($urandom_range(0, 15));
            size = $urandom;
            addr = $urandom;
            if (act == ACT_ADD) begin
                // Mostly small ranges near the window, plus refused and edge cases.
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        addr = WINDOW_BASE + $urandom_range(0, 'hFFFF);
                        size = $urandom_range(1, 'h400);
                    end
                    4: begin
                        size = $urandom_range(1, 'h10000);
                    end
                    5: begin
                        if (map_count > 0)
                            addr = 32'(map_hi[$urandom_range(0, map_count - 1)]);
                        size = $urandom_range(1, 'h100);
                    end
                    6: begin
                        size = 32'd0;
                    end
                    7: begin
                    end
                    8: begin
                        size = $urandom_range(1, 'h1000);
                        addr = 32'd0 - size;
                    end
                    default: begin
                        addr = WINDOW_BASE - $urandom_range(1, 'h100);
                        size = $urandom_range(1, 'h200);
                    end
                endcase
            end else if ((act == ACT_READ || act == ACT_WRITE) && map_count > 0 &&
                         $urandom_range(0, 99) < 70) begin
                // Aim at a stored range: its edges, just outside, or somewhere inside.
                k = $urandom_range(0, map_count - 1);
                span = longint'(map_hi[k]) - longint'(map_lo[k]);
                case ($urandom_range(0, 4))
                    0: point = map_lo[k];
                    1: point = 32'(map_hi[k] - 33'd1);
                    2: point = 32'(map_hi[k]);
                    3: point = map_lo[k] - 32'd1;
                    default: point = map_lo[k] + 32'({$urandom, $urandom} % span);
                endcase
                addr = point - WINDOW_BASE;
            end

            if (n == HOLD_AT)
                hold_req = 1'b1;
            if (n == DRAIN_AT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_decodes.size() != 0) @(posedge aclk);
            end
            // Runs of back-to-back words, including through the long hold-off.
            if ((n >= HOLD_AT && n < HOLD_AT + 40) || (n % 250) < 30 || n == DRAIN_AT)
                idle = 0;
            else
                idle = pick_idle();

            offer_word(act, addr, size, bytes, idle);
            pending_decodes.push_back(decode_predict(act, addr, size, bytes));
        end

        s_valid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("mmio_range_decoder_core_tb: done, clean");
        end else begin
            $display("mmio_range_decoder_core_tb: done, errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4000000;
        $display("mmio_range_decoder_core_tb: done, errors");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/mmiodec_pkg.sv
rtl/core/mmiodec_cell.sv
rtl/core/mmio_range_decoder_core.sv
rtl/core/mmiodec_checker.sv
tb/sv/mmio_range_decoder_core_tb.sv
